>>> rtl/core/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared constants, request and status codes, and the command and status
// structs that join the packed bit matrix controller and datapath.
// ----------------------------------------------------------------------------
package pbm_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned LogBits    = $clog2(WordBits);
  localparam int unsigned RowStride  = (MaxWidth + WordBits - 1) / WordBits;
  localparam int unsigned StoreWords = MaxHeight * RowStride;

  localparam int unsigned DimW     = 9;
  localparam int unsigned ColW     = 8;
  localparam int unsigned RowW     = 8;
  localparam int unsigned KindW    = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned WordIdxW = $clog2(RowStride);
  localparam int unsigned AddrW    = $clog2(StoreWords);

  // Request kinds
  localparam logic [KindW-1:0] KindFlip      = 3'd0;
  localparam logic [KindW-1:0] KindFill      = 3'd1;
  localparam logic [KindW-1:0] KindRead      = 3'd2;
  localparam logic [KindW-1:0] KindFindFirst = 3'd3;
  localparam logic [KindW-1:0] KindFindLast  = 3'd4;

  // Result status codes
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusBad   = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;

  typedef enum logic {
    SRC_RES,
    SRC_WORD
  } out_src_e;

  typedef struct packed {
    logic               load_req;
    logic               clr_wr;
    logic               rd_en;
    logic               wr_en;
    logic               cnt_init;
    logic               cnt_step;
    logic               res_set;
    logic [StatusW-1:0] res_status;
    logic               res_found;
    logic               out_load;
    out_src_e           out_src;
  } pbm_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             req_bad;
    logic             at_end;
    logic             hit;
    logic             clr_done;
    logic             out_free;
  } pbm_stat_t;

endpackage

>>> rtl/core/packed_bit_matrix_engine.sv
// ----------------------------------------------------------------------------
// packed_bit_matrix_engine
// Binary image held as rows of 32-bit words in a single word memory, with
// flip, region fill, row read and first/last set pixel search.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  cfg      in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//  in       in         in_valid_i / in_ready_o   kind, col_x, row_y, region size
//  out      out        out_valid_o / out_ready_i status, word, index, found, last
//
//  One request at a time; every memory access goes through one write and one
//  read port. Flip and fill are read-modify-write walks over the words touched,
//  a row read emits one word beat per word, and finds scan word by word.
//  After reset a clearing pass writes all 2048 words before the first request
//  is taken; size writes are taken throughout.
//  A stalled output holds its beat; the next request is taken while it waits.
//
module packed_bit_matrix_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pbm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pbm_pkg::DimW-1:0]          cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pbm_pkg::KindW-1:0]         kind_i,
  input  logic [pbm_pkg::ColW-1:0]          col_x_i,
  input  logic [pbm_pkg::RowW-1:0]          row_y_i,
  input  logic [pbm_pkg::DimW-1:0]          region_width_i,
  input  logic [pbm_pkg::DimW-1:0]          region_height_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pbm_pkg::StatusW-1:0]       status_o,
  output logic [pbm_pkg::WordBits-1:0]      word_data_o,
  output logic [pbm_pkg::WordIdxW-1:0]      word_index_o,
  output logic [pbm_pkg::ColW-1:0]          found_x_o,
  output logic [pbm_pkg::RowW-1:0]          found_y_o,
  output logic                              last_o
);

  pbm_pkg::pbm_cmd_t  cmd;
  pbm_pkg::pbm_stat_t stat;

  pbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pbm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (kind_i),
    .col_x_i         (col_x_i),
    .row_y_i         (row_y_i),
    .region_width_i  (region_width_i),
    .region_height_i (region_height_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .word_data_o     (word_data_o),
    .word_index_o    (word_index_o),
    .found_x_o       (found_x_o),
    .found_y_o       (found_y_o),
    .last_o          (last_o)
  );

`ifndef SYNTH
  a_one_request_at_a_time : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o
  ) else $error("input taken again straight after a request");

  a_load_only_when_free : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free
  ) else $error("output register loaded over a pending beat");

  a_write_after_read : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> $past(cmd.rd_en)
  ) else $error("modify write without a preceding word read");
`endif

endmodule

>>> rtl/core/pbm_ctrl.sv
// ----------------------------------------------------------------------------
// pbm_ctrl
// Request sequencer: clearing pass, decode, read-modify-write walks, row
// reads and pipelined scans over the word memory.
// ----------------------------------------------------------------------------
module pbm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pbm_pkg::pbm_stat_t stat_i,
  output pbm_pkg::pbm_cmd_t  cmd_o
);

  localparam logic [3:0] StClear    = 4'd0;
  localparam logic [3:0] StIdle     = 4'd1;
  localparam logic [3:0] StDecode   = 4'd2;
  localparam logic [3:0] StRdMod    = 4'd3;
  localparam logic [3:0] StWrMod    = 4'd4;
  localparam logic [3:0] StRdRow    = 4'd5;
  localparam logic [3:0] StEmitWord = 4'd6;
  localparam logic [3:0] StScan0    = 4'd7;
  localparam logic [3:0] StScan     = 4'd8;
  localparam logic [3:0] StTail     = 4'd9;
  localparam logic [3:0] StEmit     = 4'd10;

  logic [3:0]        state_q, state_d;
  pbm_pkg::pbm_cmd_t cmd;

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load_req = 1'b1;
          state_d      = StDecode;
        end
      end
      StDecode: begin
        if (stat_i.req_bad) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = pbm_pkg::StatusBad;
          state_d        = StEmit;
        end else begin
          cmd.cnt_init = 1'b1;
          case (stat_i.kind) inside
            pbm_pkg::KindFlip, pbm_pkg::KindFill: begin
              state_d = StRdMod;
            end
            pbm_pkg::KindRead: begin
              state_d = StRdRow;
            end
            default: begin
              state_d = StScan0;
            end
          endcase
        end
      end
      StRdMod: begin
        cmd.rd_en = 1'b1;
        state_d   = StWrMod;
      end
      StWrMod: begin
        cmd.wr_en = 1'b1;
        if (stat_i.at_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = pbm_pkg::StatusOk;
          state_d        = StEmit;
        end else begin
          cmd.cnt_step = 1'b1;
          state_d      = StRdMod;
        end
      end
      StRdRow: begin
        cmd.rd_en = 1'b1;
        state_d   = StEmitWord;
      end
      StEmitWord: begin
        if (stat_i.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = pbm_pkg::SRC_WORD;
          if (stat_i.at_end) begin
            state_d = StIdle;
          end else begin
            cmd.cnt_step = 1'b1;
            state_d      = StRdRow;
          end
        end
      end
      StScan0: begin
        cmd.rd_en = 1'b1;
        if (stat_i.at_end) begin
          state_d = StTail;
        end else begin
          cmd.cnt_step = 1'b1;
          state_d      = StScan;
        end
      end
      StScan: begin
        // check the word read last cycle while issuing the next one
        if (stat_i.hit) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = pbm_pkg::StatusOk;
          cmd.res_found  = 1'b1;
          state_d        = StEmit;
        end else begin
          cmd.rd_en = 1'b1;
          if (stat_i.at_end) begin
            state_d = StTail;
          end else begin
            cmd.cnt_step = 1'b1;
          end
        end
      end
      StTail: begin
        cmd.res_set = 1'b1;
        if (stat_i.hit) begin
          cmd.res_status = pbm_pkg::StatusOk;
          cmd.res_found  = 1'b1;
        end else begin
          cmd.res_status = pbm_pkg::StatusEmpty;
        end
        state_d = StEmit;
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = pbm_pkg::SRC_RES;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/pbm_dp.sv
// ----------------------------------------------------------------------------
// pbm_dp
// Datapath: size registers, request registers, row and word counters, the
// pixel word memory, read-modify-write masks, bit search and result register.
// ----------------------------------------------------------------------------
module pbm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pbm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pbm_pkg::DimW-1:0]          cfg_wdata_i,
  input  logic [pbm_pkg::KindW-1:0]         kind_i,
  input  logic [pbm_pkg::ColW-1:0]          col_x_i,
  input  logic [pbm_pkg::RowW-1:0]          row_y_i,
  input  logic [pbm_pkg::DimW-1:0]          region_width_i,
  input  logic [pbm_pkg::DimW-1:0]          region_height_i,
  input  pbm_pkg::pbm_cmd_t                 cmd_i,
  output pbm_pkg::pbm_stat_t                stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pbm_pkg::StatusW-1:0]       status_o,
  output logic [pbm_pkg::WordBits-1:0]      word_data_o,
  output logic [pbm_pkg::WordIdxW-1:0]      word_index_o,
  output logic [pbm_pkg::ColW-1:0]          found_x_o,
  output logic [pbm_pkg::RowW-1:0]          found_y_o,
  output logic                              last_o
);

  localparam int unsigned WB  = pbm_pkg::WordBits;
  localparam int unsigned LB  = pbm_pkg::LogBits;
  localparam int unsigned CW  = pbm_pkg::ColW;
  localparam int unsigned RW  = pbm_pkg::RowW;
  localparam int unsigned DW  = pbm_pkg::DimW;
  localparam int unsigned IW  = pbm_pkg::WordIdxW;
  localparam int unsigned SW  = pbm_pkg::StatusW;

  function automatic logic [LB-1:0] low_bit(input logic [WB-1:0] v);
    logic [LB-1:0] pos;
    pos = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = LB'(i);
      end
    end
    return pos;
  endfunction

  function automatic logic [LB-1:0] high_bit(input logic [WB-1:0] v);
    logic [LB-1:0] pos;
    pos = '0;
    for (int i = 0; i < WB; i++) begin
      if (v[i]) begin
        pos = LB'(i);
      end
    end
    return pos;
  endfunction

  // Size registers and their effective values
  logic [DW-1:0] width_q, height_q;
  logic [DW-1:0] eff_w, eff_h, w_m1, h_m1;
  logic [IW-1:0] last_word;
  logic [RW-1:0] last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DW'(pbm_pkg::MaxWidth);
      height_q <= DW'(pbm_pkg::MaxHeight);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbm_pkg::RegWidth:  width_q  <= cfg_wdata_i;
        pbm_pkg::RegHeight: height_q <= cfg_wdata_i;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = DW'(1);
    end else if (width_q > DW'(pbm_pkg::MaxWidth)) begin
      eff_w = DW'(pbm_pkg::MaxWidth);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = DW'(1);
    end else if (height_q > DW'(pbm_pkg::MaxHeight)) begin
      eff_h = DW'(pbm_pkg::MaxHeight);
    end else begin
      eff_h = height_q;
    end
  end

  assign w_m1      = eff_w - DW'(1);
  assign h_m1      = eff_h - DW'(1);
  assign last_word = w_m1[CW-1:LB];
  assign last_row  = h_m1[RW-1:0];

  // Request registers
  logic [pbm_pkg::KindW-1:0] kind_q;
  logic [CW-1:0]             x_q;
  logic [RW-1:0]             y_q;
  logic [DW-1:0]             rw_q, rh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q <= kind_i;
      x_q    <= col_x_i;
      y_q    <= row_y_i;
      rw_q   <= region_width_i;
      rh_q   <= region_height_i;
    end
  end

  logic [DW:0]   right, bottom, right_m1, bottom_m1;
  logic [IW-1:0] fill_first, fill_lw;
  logic          req_bad;

  assign right      = {1'b0, DW'(x_q)} + {1'b0, rw_q};
  assign bottom     = {1'b0, DW'(y_q)} + {1'b0, rh_q};
  assign right_m1   = right - (DW + 1)'(1);
  assign bottom_m1  = bottom - (DW + 1)'(1);
  assign fill_first = x_q[CW-1:LB];
  assign fill_lw    = right_m1[CW-1:LB];

  always_comb begin
    case (kind_q) inside
      pbm_pkg::KindFlip: begin
        req_bad = (DW'(x_q) >= eff_w) || (DW'(y_q) >= eff_h);
      end
      pbm_pkg::KindFill: begin
        req_bad = (rw_q == '0) || (rh_q == '0) ||
                  (right > {1'b0, eff_w}) || (bottom > {1'b0, eff_h});
      end
      pbm_pkg::KindRead: begin
        req_bad = DW'(y_q) >= eff_h;
      end
      pbm_pkg::KindFindFirst, pbm_pkg::KindFindLast: begin
        req_bad = 1'b0;
      end
      default: begin
        req_bad = 1'b1;
      end
    endcase
  end

  // Row and word walk counters
  logic [RW-1:0] row_q, row_d;
  logic [IW-1:0] word_q, word_d;
  logic          at_end;

  always_comb begin
    row_d  = row_q;
    word_d = word_q;
    if (cmd_i.cnt_init) begin
      case (kind_q) inside
        pbm_pkg::KindFlip, pbm_pkg::KindFill: begin
          row_d  = y_q;
          word_d = fill_first;
        end
        pbm_pkg::KindRead: begin
          row_d  = y_q;
          word_d = '0;
        end
        pbm_pkg::KindFindFirst: begin
          row_d  = '0;
          word_d = '0;
        end
        default: begin
          row_d  = last_row;
          word_d = last_word;
        end
      endcase
    end else if (cmd_i.cnt_step) begin
      case (kind_q)
        pbm_pkg::KindFill: begin
          if (word_q == fill_lw) begin
            word_d = fill_first;
            row_d  = row_q + RW'(1);
          end else begin
            word_d = word_q + IW'(1);
          end
        end
        pbm_pkg::KindRead: begin
          word_d = word_q + IW'(1);
        end
        pbm_pkg::KindFindFirst: begin
          if (word_q == last_word) begin
            word_d = '0;
            row_d  = row_q + RW'(1);
          end else begin
            word_d = word_q + IW'(1);
          end
        end
        default: begin
          // walk backwards for find last
          if (word_q == '0) begin
            word_d = last_word;
            row_d  = row_q - RW'(1);
          end else begin
            word_d = word_q - IW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    word_q <= word_d;
  end

  always_comb begin
    case (kind_q)
      pbm_pkg::KindFill:      at_end = (word_q == fill_lw) && (row_q == bottom_m1[RW-1:0]);
      pbm_pkg::KindRead:      at_end = word_q == last_word;
      pbm_pkg::KindFindFirst: at_end = (row_q == last_row) && (word_q == last_word);
      pbm_pkg::KindFindLast:  at_end = (row_q == '0) && (word_q == '0);
      default:                at_end = 1'b1;
    endcase
  end

  // Clearing pass counter
  logic [pbm_pkg::AddrW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + pbm_pkg::AddrW'(1);
    end
  end

  // Pixel word memory: one write and one registered read per cycle
  logic [WB-1:0]             mem [pbm_pkg::StoreWords];
  logic [WB-1:0]             rd_data_q;
  logic [RW-1:0]             chk_row_q;
  logic [IW-1:0]             chk_word_q;
  logic [pbm_pkg::AddrW-1:0] cnt_addr, wr_addr;
  logic [WB-1:0]             wr_data, mod_data, fill_mask;
  logic [LB-1:0]             lo, hi;
  logic                      mem_we;

  assign cnt_addr = {row_q, word_q};

  assign lo        = (word_q == fill_first) ? x_q[LB-1:0] : '0;
  assign hi        = (word_q == fill_lw) ? right_m1[LB-1:0] : '1;
  assign fill_mask = ({WB{1'b1}} << lo) & ({WB{1'b1}} >> (LB'(WB - 1) - hi));
  assign mod_data  = (kind_q == pbm_pkg::KindFlip) ?
                     (rd_data_q ^ (WB'(1) << x_q[LB-1:0])) :
                     (rd_data_q | fill_mask);

  assign mem_we  = cmd_i.clr_wr || cmd_i.wr_en;
  assign wr_addr = cmd_i.clr_wr ? clr_q : cnt_addr;
  assign wr_data = cmd_i.clr_wr ? '0 : mod_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q  <= mem[cnt_addr];
      chk_row_q  <= row_q;
      chk_word_q <= word_q;
    end
  end

  // Hide columns beyond the width in use
  logic [WB-1:0] vis_mask, masked;
  logic [LB-1:0] bit_pos;
  logic [CW-1:0] found_x;

  assign vis_mask = (chk_word_q == last_word) ?
                    ({WB{1'b1}} >> (LB'(WB - 1) - w_m1[LB-1:0])) : {WB{1'b1}};
  assign masked   = rd_data_q & vis_mask;
  assign bit_pos  = (kind_q == pbm_pkg::KindFindLast) ? high_bit(masked) : low_bit(masked);
  assign found_x  = {chk_word_q, bit_pos};

  // Single-beat result, held until the output register is free
  logic [SW-1:0] res_status_q;
  logic [CW-1:0] res_fx_q;
  logic [RW-1:0] res_fy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_fx_q     <= cmd_i.res_found ? found_x : '0;
      res_fy_q     <= cmd_i.res_found ? chk_row_q : '0;
    end
  end

  // Output register
  logic          out_v_q;
  logic [SW-1:0] status_q;
  logic [WB-1:0] data_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] fx_q;
  logic [RW-1:0] fy_q;
  logic          last_q;
  logic          out_free;

  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_src == pbm_pkg::SRC_WORD) begin
        status_q <= pbm_pkg::StatusOk;
        data_q   <= masked;
        idx_q    <= chk_word_q;
        fx_q     <= '0;
        fy_q     <= '0;
        last_q   <= at_end;
      end else begin
        status_q <= res_status_q;
        data_q   <= '0;
        idx_q    <= '0;
        fx_q     <= res_fx_q;
        fy_q     <= res_fy_q;
        last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign status_o     = status_q;
  assign word_data_o  = data_q;
  assign word_index_o = idx_q;
  assign found_x_o    = fx_q;
  assign found_y_o    = fy_q;
  assign last_o       = last_q;

  assign stat_o.kind     = kind_q;
  assign stat_o.req_bad  = req_bad;
  assign stat_o.at_end   = at_end;
  assign stat_o.hit      = |masked;
  assign stat_o.clr_done = &clr_q;
  assign stat_o.out_free = out_free;

endmodule
